@@ src/impq_pkg.sv @@
package impq_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int POS_W     = $clog2(CAPACITY + 1);

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [KEY_WIDTH-1:0] key_t;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_CHANGE = 3'd1,
        CMD_POP    = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // Request from the sequencer to the key comparator.
    typedef struct packed {
        key_t a;
        key_t b;
    } cmp_req_t;

endpackage

@@ src/impq_cmp.sv @@
module impq_cmp
    import impq_pkg::*;
(
    input  cmp_req_t req,
    output logic     a_less
);

    // Signed compare of two keys; this is the one shared compare unit.
    assign a_less = $signed(req.a) < $signed(req.b);

endmodule

@@ src/indexed_min_priority_queue_unit.sv @@
// Indexed binary min-heap over 64 slots with signed 32-bit keys, one command at a time.
// Errors and unknown commands end after the check, read key after one heap read, and
// a pop or remove of the entry at the last heap position after the take; other inserts,
// changes, pops and removes run a swim walk and, but for insert, a sink walk.
// Busy falls as the result strobe rises.
// Reset (rst_n low, asynchronous) empties the queue; the receiver cannot stall.
module indexed_min_priority_queue_unit
    import impq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           cmd,
    input  logic [5:0]           slot,
    input  logic signed [31:0]   key_in,
    output logic                 done,
    output logic [1:0]           status,
    output logic [5:0]           popped_slot,
    output logic signed [31:0]   key_out,
    output logic [6:0]           count,
    output logic [5:0]           top_slot,
    output logic                 top_valid
);

    // The heap is kept in two memories with registered read data. The heap memory
    // holds, for each heap position, the slot found there together with its key, so
    // one read gives both. The position memory holds the heap position of each slot.
    // A present bit per slot marks which slots hold an entry; the position memory
    // read is only used for present slots.
    //
    // Swim and sink move a "hole" instead of swapping: the entry being placed is
    // held in a register, each entry that has to make room is written into the
    // hole, and the held entry is written once where the walk stops. This gives
    // the same final order as pairwise swaps with one write per memory per cycle.
    // All key compares go through the single shared comparator.
    //
    // The slot at heap position 1 is mirrored in a register so that the top slot
    // is always on the outputs without a memory read.

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_READ_GET, S_TAKE, S_TAKE_GET, S_SWIM, S_SWIM_CMP,
        S_SINK, S_SINK_C1, S_SINK_C2, S_SINK_CMP, S_PLACE, S_DONE
    } state_t;

    typedef struct packed {
        slot_t slot;
        key_t  key;
    } entry_t;

    state_t state_reg;

    entry_t heap_mem [CAPACITY];
    pos_t   pos_mem  [CAPACITY];
    entry_t hr_data_reg;
    pos_t   pr_data_reg;

    logic [CAPACITY-1:0] present_reg;
    pos_t   cnt_reg;
    slot_t  top_reg;

    logic [2:0] cmd_reg;
    slot_t      slot_reg;
    key_t       key_reg;
    pos_t       p_reg;
    pos_t       c_reg;
    entry_t     mv_reg;
    entry_t     cand_reg;
    logic       sink_after_reg;

    logic [1:0] status_reg;
    slot_t      popped_reg;
    key_t       kout_reg;
    logic       done_reg;

    cmp_req_t cmp_req;
    logic     cmp_less;

    logic   hr_en;
    slot_t  hr_addr;
    logic   pr_en;
    slot_t  pr_addr;
    logic   hw_en;
    slot_t  hw_addr;
    entry_t hw_data;
    logic   pw_en;
    slot_t  pw_addr;
    pos_t   pw_data;

    pos_t  par;
    pos_t  c1;
    pos_t  c2;
    logic  present;
    logic  has_c1;
    logic  has_c2;
    slot_t take_slot;
    logic [POS_W:0] c1w;

    impq_cmp u_cmp (.req(cmp_req), .a_less(cmp_less));

    // Heap positions run from 1 to CAPACITY; memory words from 0.
    function automatic slot_t pos_index(input pos_t p);
        pos_t q;
        q = p - pos_t'(1);
        return q[SLOT_W-1:0];
    endfunction

    assign par       = p_reg >> 1;
    assign c1w       = {p_reg, 1'b0};
    assign c1        = c1w[POS_W-1:0];
    assign c2        = c1 + pos_t'(1);
    assign has_c1    = c1w <= {1'b0, cnt_reg};
    assign has_c2    = c1 < cnt_reg;
    assign present   = present_reg[slot_reg];
    // Pop takes out the root entry, remove the addressed slot.
    assign take_slot = (cmd_reg == CMD_POP) ? hr_data_reg.slot : slot_reg;

    // Read addresses and comparator operands. The position of the addressed
    // slot is fetched at the accepting edge so it is ready in the check state.
    always_comb
    begin
        hr_en       = 1'b0;
        hr_addr     = '0;
        pr_en       = 1'b0;
        pr_addr     = slot;
        cmp_req.a   = mv_reg.key;
        cmp_req.b   = cand_reg.key;
        unique case (state_reg)
            S_IDLE:
            begin
                pr_en = start;
            end
            S_CHECK:
            begin
                // Pop needs the root entry, read key the entry of the slot.
                hr_en   = 1'b1;
                hr_addr = (cmd_reg == CMD_POP) ? '0 : pos_index(pr_data_reg);
            end
            S_TAKE:
            begin
                // The last heap entry is the one that refills the hole.
                hr_en   = 1'b1;
                hr_addr = pos_index(cnt_reg);
            end
            S_SWIM:
            begin
                hr_en   = p_reg != pos_t'(1);
                hr_addr = pos_index(par);
            end
            S_SWIM_CMP:
            begin
                cmp_req.a = mv_reg.key;
                cmp_req.b = hr_data_reg.key;
            end
            S_SINK:
            begin
                hr_en   = has_c1;
                hr_addr = pos_index(c1);
            end
            S_SINK_C1:
            begin
                hr_en   = has_c2;
                hr_addr = pos_index(c2);
            end
            S_SINK_C2:
            begin
                // The right child wins only when strictly smaller.
                cmp_req.a = hr_data_reg.key;
                cmp_req.b = cand_reg.key;
            end
            S_SINK_CMP:
            begin
                cmp_req.a = cand_reg.key;
                cmp_req.b = mv_reg.key;
            end
            default:
            begin
            end
        endcase
    end

    // Write ports: everything written goes to the hole position p_reg.
    always_comb
    begin
        hw_en   = 1'b0;
        hw_addr = pos_index(p_reg);
        hw_data = mv_reg;
        pw_en   = 1'b0;
        pw_addr = mv_reg.slot;
        pw_data = p_reg;
        unique case (state_reg)
            S_SWIM_CMP:
            begin
                // A larger parent moves down into the hole.
                hw_en   = cmp_less;
                hw_data = hr_data_reg;
                pw_en   = cmp_less;
                pw_addr = hr_data_reg.slot;
            end
            S_SINK_CMP:
            begin
                // A smaller child moves up into the hole.
                hw_en   = cmp_less;
                hw_data = cand_reg;
                pw_en   = cmp_less;
                pw_addr = cand_reg.slot;
            end
            S_PLACE:
            begin
                hw_en = 1'b1;
                pw_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            heap_mem[hw_addr] <= hw_data;
        end
        if (pw_en)
        begin
            pos_mem[pw_addr] <= pw_data;
        end
        if (hr_en)
        begin
            hr_data_reg <= heap_mem[hr_addr];
        end
        if (pr_en)
        begin
            pr_data_reg <= pos_mem[pr_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            present_reg    <= '0;
            cnt_reg        <= '0;
            top_reg        <= '0;
            cmd_reg        <= '0;
            slot_reg       <= '0;
            key_reg        <= '0;
            p_reg          <= '0;
            c_reg          <= '0;
            mv_reg         <= '0;
            cand_reg       <= '0;
            sink_after_reg <= 1'b0;
            done_reg       <= 1'b0;
            status_reg     <= ST_OK;
            popped_reg     <= '0;
            kout_reg       <= '0;
        end
        else
        begin
            done_reg <= state_reg == S_DONE;
            if (hw_en && p_reg == pos_t'(1))
            begin
                top_reg <= hw_data.slot;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg    <= cmd;
                        slot_reg   <= slot;
                        key_reg    <= key_in;
                        status_reg <= ST_OK;
                        popped_reg <= '0;
                        kout_reg   <= '0;
                        state_reg  <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (present)
                            begin
                                status_reg <= ST_PRESENT;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                // The new entry starts in a hole after the last one.
                                present_reg[slot_reg] <= 1'b1;
                                cnt_reg        <= cnt_reg + pos_t'(1);
                                p_reg          <= cnt_reg + pos_t'(1);
                                mv_reg.slot    <= slot_reg;
                                mv_reg.key     <= key_reg;
                                sink_after_reg <= 1'b0;
                                state_reg      <= S_SWIM;
                            end
                        end
                        CMD_CHANGE:
                        begin
                            if (!present)
                            begin
                                status_reg <= ST_ABSENT;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                p_reg          <= pr_data_reg;
                                mv_reg.slot    <= slot_reg;
                                mv_reg.key     <= key_reg;
                                sink_after_reg <= 1'b1;
                                state_reg      <= S_SWIM;
                            end
                        end
                        CMD_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_reg <= ST_EMPTY;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                p_reg     <= pos_t'(1);
                                state_reg <= S_TAKE;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            // An empty queue is reported before the presence check.
                            if (cnt_reg == '0)
                            begin
                                status_reg <= ST_EMPTY;
                                state_reg  <= S_DONE;
                            end
                            else if (!present)
                            begin
                                status_reg <= ST_ABSENT;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                p_reg     <= pr_data_reg;
                                state_reg <= S_TAKE;
                            end
                        end
                        CMD_READ:
                        begin
                            if (!present)
                            begin
                                status_reg <= ST_ABSENT;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_READ_GET;
                            end
                        end
                        default:
                        begin
                            // Unknown command codes change nothing and report ok.
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_READ_GET:
                begin
                    kout_reg  <= hr_data_reg.key;
                    state_reg <= S_DONE;
                end
                S_TAKE:
                begin
                    // Take the entry at p_reg out. When it was the last one there
                    // is nothing to refill; otherwise the last entry fills the hole.
                    if (cmd_reg == CMD_POP)
                    begin
                        popped_reg <= hr_data_reg.slot;
                        kout_reg   <= hr_data_reg.key;
                    end
                    present_reg[take_slot] <= 1'b0;
                    cnt_reg <= cnt_reg - pos_t'(1);
                    state_reg <= (p_reg == cnt_reg) ? S_DONE : S_TAKE_GET;
                end
                S_TAKE_GET:
                begin
                    mv_reg         <= hr_data_reg;
                    sink_after_reg <= 1'b1;
                    state_reg      <= S_SWIM;
                end
                S_SWIM:
                begin
                    if (p_reg == pos_t'(1))
                    begin
                        state_reg <= sink_after_reg ? S_SINK : S_PLACE;
                    end
                    else
                    begin
                        state_reg <= S_SWIM_CMP;
                    end
                end
                S_SWIM_CMP:
                begin
                    // The held entry rises only past a strictly greater parent.
                    if (cmp_less)
                    begin
                        p_reg     <= par;
                        state_reg <= S_SWIM;
                    end
                    else
                    begin
                        state_reg <= sink_after_reg ? S_SINK : S_PLACE;
                    end
                end
                S_SINK:
                begin
                    state_reg <= has_c1 ? S_SINK_C1 : S_PLACE;
                end
                S_SINK_C1:
                begin
                    cand_reg  <= hr_data_reg;
                    c_reg     <= c1;
                    state_reg <= has_c2 ? S_SINK_C2 : S_SINK_CMP;
                end
                S_SINK_C2:
                begin
                    if (cmp_less)
                    begin
                        cand_reg <= hr_data_reg;
                        c_reg    <= c2;
                    end
                    state_reg <= S_SINK_CMP;
                end
                S_SINK_CMP:
                begin
                    // The chosen child moves up only when strictly smaller.
                    if (cmp_less)
                    begin
                        p_reg     <= c_reg;
                        state_reg <= S_SINK;
                    end
                    else
                    begin
                        state_reg <= S_PLACE;
                    end
                end
                S_PLACE:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = state_reg != S_IDLE;
    assign done        = done_reg;
    assign status      = status_reg;
    assign popped_slot = popped_reg;
    assign key_out     = kout_reg;
    assign count       = cnt_reg;
    assign top_valid   = cnt_reg != '0;
    assign top_slot    = top_valid ? top_reg : '0;

    property p_done_idle;
        @(posedge clk) disable iff (!rst_n) done |-> !busy;
    endproperty
    assert property (p_done_idle) else $error("result strobe while busy");

    property p_count_step;
        @(posedge clk) disable iff (!rst_n)
            done |-> (count == $past(count, 1));
    endproperty
    assert property (p_count_step) else $error("count moved at result");

    property p_empty_top;
        @(posedge clk) disable iff (!rst_n) (count == '0) |-> !top_valid;
    endproperty
    assert property (p_empty_top) else $error("top valid on empty queue");

    property p_accept_busy;
        @(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy;
    endproperty
    assert property (p_accept_busy) else $error("accepted word did not raise busy");

endmodule

@@ test/indexed_min_priority_queue_unit_tb.sv @@
module indexed_min_priority_queue_unit_tb;
    import impq_pkg::*;

    // Command codes above CMD_READ are not decoded by the block; they must
    // leave the queue untouched and answer with an ok status.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    localparam int RANDOM_WORDS = 360;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    // One result word as the block should present it.
    typedef struct {
        status_t    st;
        slot_t      popped;
        key_t       key;
        logic [6:0] cnt;
        slot_t      top;
        logic       top_ok;
    } heap_result_t;

    // Scoreboard: keeps its own indexed min-heap, derives the expected result
    // of every accepted command word and checks the result words in order.
    class heap_scoreboard;
        logic signed [31:0] key_of[CAPACITY];
        int                 pos_of[CAPACITY];
        int                 at_pos[CAPACITY+1];
        int                 fill;
        heap_result_t       pending_q[$];
        int                 errors;
        int                 checked;
        int                 cmd_seen[8];
        int                 status_seen[4];
        int                 full_seen;

        function new();
            for (int i = 0; i < CAPACITY; i++)
            begin
                key_of[i] = '0;
                pos_of[i] = 0;
            end
            for (int i = 0; i <= CAPACITY; i++)
            begin
                at_pos[i] = 0;
            end
            fill = 0;
            errors = 0;
            checked = 0;
            full_seen = 0;
        endfunction

        function bit is_present(int s);
            return pos_of[s] != 0;
        endfunction

        function bit lower(int a, int b);
            return key_of[at_pos[a]] < key_of[at_pos[b]];
        endfunction

        function void exchange(int a, int b);
            int t;
            t = at_pos[a];
            at_pos[a] = at_pos[b];
            at_pos[b] = t;
            pos_of[at_pos[a]] = a;
            pos_of[at_pos[b]] = b;
        endfunction

        function int rise(int p);
            while (p > 1 && lower(p, p / 2))
            begin
                exchange(p, p / 2);
                p = p / 2;
            end
            return p;
        endfunction

        function void settle(int p);
            int c;
            while (2 * p <= fill)
            begin
                c = 2 * p;
                if (c + 1 <= fill && lower(c + 1, c))
                    c++;
                if (!lower(c, p))
                    break;
                exchange(p, c);
                p = c;
            end
        endfunction

        // The last heap entry fills the hole and is moved up or down from there.
        function void extract(int p);
            int gone;
            gone = at_pos[p];
            if (p != fill)
                exchange(p, fill);
            pos_of[gone] = 0;
            fill--;
            if (p <= fill)
                settle(rise(p));
        endfunction

        function void note_word(logic [2:0] c, slot_t s, key_t k);
            heap_result_t r;
            bit here;
            here = is_present(int'(s));
            r.st = ST_OK;
            r.popped = '0;
            r.key = '0;
            cmd_seen[c]++;
            case (c)
                CMD_INSERT:
                begin
                    if (here)
                        r.st = ST_PRESENT;
                    else
                    begin
                        fill++;
                        at_pos[fill] = int'(s);
                        pos_of[s] = fill;
                        key_of[s] = k;
                        void'(rise(fill));
                    end
                end
                CMD_CHANGE:
                begin
                    if (!here)
                        r.st = ST_ABSENT;
                    else
                    begin
                        key_of[s] = k;
                        settle(rise(pos_of[s]));
                    end
                end
                CMD_POP:
                begin
                    if (fill == 0)
                        r.st = ST_EMPTY;
                    else
                    begin
                        r.popped = slot_t'(at_pos[1]);
                        r.key = key_of[at_pos[1]];
                        extract(1);
                    end
                end
                CMD_REMOVE:
                begin
                    if (fill == 0)
                        r.st = ST_EMPTY;
                    else if (!here)
                        r.st = ST_ABSENT;
                    else
                        extract(pos_of[s]);
                end
                CMD_READ:
                begin
                    if (!here)
                        r.st = ST_ABSENT;
                    else
                        r.key = key_of[s];
                end
                default:
                begin
                end
            endcase
            r.cnt = 7'(fill);
            r.top = (fill != 0) ? slot_t'(at_pos[1]) : '0;
            r.top_ok = (fill != 0);
            status_seen[r.st]++;
            if (fill == CAPACITY)
                full_seen++;
            pending_q = {pending_q, r};
        endfunction

        function void check_word(logic [1:0] st, slot_t ps, key_t ko, logic [6:0] cnt,
                                 slot_t top, logic tv);
            heap_result_t e;
            if (pending_q.size() == 0)
            begin
                $error("result word arrived with no command outstanding");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (st !== e.st)
            begin
                $error("status expected %0d got %0d", e.st, st);
                errors++;
            end
            if (ps !== e.popped)
            begin
                $error("popped_slot expected %0d got %0d", e.popped, ps);
                errors++;
            end
            if (ko !== e.key)
            begin
                $error("key_out expected %0d got %0d", $signed(e.key), $signed(ko));
                errors++;
            end
            if (cnt !== e.cnt)
            begin
                $error("count expected %0d got %0d", e.cnt, cnt);
                errors++;
            end
            if (top !== e.top)
            begin
                $error("top_slot expected %0d got %0d", e.top, top);
                errors++;
            end
            if (tv !== e.top_ok)
            begin
                $error("top_valid expected %0d got %0d", e.top_ok, tv);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         cmd;
    logic [5:0]         slot;
    logic signed [31:0] key_in;
    logic               done;
    logic [1:0]         status;
    logic [5:0]         popped_slot;
    logic signed [31:0] key_out;
    logic [6:0]         count;
    logic [5:0]         top_slot;
    logic               top_valid;

    heap_scoreboard sb;
    int             cycles = 0;
    bit             idle_allowed;

    indexed_min_priority_queue_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .slot        (slot),
        .key_in      (key_in),
        .done        (done),
        .status      (status),
        .popped_slot (popped_slot),
        .key_out     (key_out),
        .count       (count),
        .top_slot    (top_slot),
        .top_valid   (top_valid)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Both monitors sample at the rising edge, so they see the values that
    // were settled during the cycle that the edge ends.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_word(cmd, slot, key_in);
        if (rst_n && done)
            sb.check_word(status, popped_slot, key_out, count, top_slot, top_valid);
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Present one command word and hold it until the block takes it. With
    // idling allowed, start is sometimes dropped afterwards; otherwise it
    // stays high so the next word follows back to back.
    task automatic send_word(input logic [2:0] c, input int s, input logic [31:0] k);
        start  <= 1'b1;
        cmd    <= c;
        slot   <= s[5:0];
        key_in <= k;
        do
            @(posedge clk);
        while (busy);
        if (idle_allowed && $urandom_range(99) < 23)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // The first edge lets the monitor note a word taken at the current edge.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_q.size() != 0);
    endtask

    // A present slot is picked most of the time so that change, remove and
    // read reach the heap walk rather than the error path.
    function automatic int pick_slot(bit want_present);
        int s;
        for (int tries = 0; tries < 64; tries++)
        begin
            s = $urandom_range(CAPACITY - 1);
            if (sb.is_present(s) == want_present)
                return s;
        end
        return $urandom_range(CAPACITY - 1);
    endfunction

    // Narrow key ranges produce many equal keys, which exercises the strict
    // tie rules of swim and sink; the rest spans the whole signed range.
    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4)
            return $urandom_range(7) - 4;
        else if (sel == 4)
            return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
        else
            return $urandom;
    endfunction

    task automatic random_word(bit filling);
        int          sel;
        logic [2:0]  c;
        int          s;
        sel = $urandom_range(99);
        if (sel < (filling ? 60 : 25))
            c = CMD_INSERT;
        else if (sel < 45)
            c = CMD_CHANGE;
        else if (sel < 62)
            c = CMD_POP;
        else if (sel < 78)
            c = CMD_REMOVE;
        else if (sel < 95)
            c = CMD_READ;
        else
            c = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        s = pick_slot((c == CMD_INSERT) ? ($urandom_range(9) == 0)
                                        : ($urandom_range(9) != 0));
        send_word(c, s, pick_key());
    endtask

    initial
    begin
        sb = new();
        idle_allowed = 1'b1;
        rst_n  = 1'b0;
        start  = 1'b0;
        cmd    = CMD_READ;
        slot   = '0;
        key_in = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty-queue errors, absent slots, the key extremes,
        // a duplicate insert, ties, and the undecoded command codes.
        send_word(CMD_POP, 0, 0);
        send_word(CMD_REMOVE, 5, 0);
        send_word(CMD_READ, 63, 0);
        send_word(CMD_CHANGE, 9, 1);
        send_word(CMD_INSERT, 63, 32'h7fffffff);
        send_word(CMD_INSERT, 0, 32'h80000000);
        send_word(CMD_INSERT, 42, 32'h0);
        send_word(CMD_INSERT, 21, 32'h0);
        send_word(CMD_INSERT, 0, 32'h5);
        send_word(CMD_READ, 0, 0);
        send_word(CMD_READ, 63, 0);
        send_word(CMD_REMOVE, 7, 0);
        send_word(CMD_CHANGE, 63, 32'hffffffff);
        send_word(CMD_CHANGE, 0, 32'h7fffffff);
        send_word(CMD_SPARE_FIRST, 3, 32'h1234);
        send_word(CMD_SPARE_MID, 21, 32'hdeadbeef);
        send_word(CMD_SPARE_LAST, 42, 32'h55555555);
        send_word(CMD_REMOVE, 42, 0);
        send_word(CMD_POP, 0, 0);
        send_word(CMD_POP, 0, 0);
        send_word(CMD_POP, 0, 0);
        send_word(CMD_POP, 0, 0);

        // Fill to capacity once so the count reaches its maximum and every
        // further insert meets an occupied slot.
        for (int s = 0; s < CAPACITY; s++)
            send_word(CMD_INSERT, (s * 37) % CAPACITY, pick_key());
        send_word(CMD_INSERT, 17, 32'h1);

        // The sender holds off here until every result has come back.
        wait_drained();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            idle_allowed = !(i >= 200 && i < 300);
            random_word((i / 60) % 2 == 0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results; ins %0d chg %0d pop %0d rem %0d rd %0d",
                 sb.checked, sb.cmd_seen[CMD_INSERT], sb.cmd_seen[CMD_CHANGE],
                 sb.cmd_seen[CMD_POP], sb.cmd_seen[CMD_REMOVE], sb.cmd_seen[CMD_READ]);
        $display("Statuses ok/present/absent/empty: %0d/%0d/%0d/%0d, full-queue words %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_PRESENT],
                 sb.status_seen[ST_ABSENT], sb.status_seen[ST_EMPTY], sb.full_seen);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/impq_pkg.sv
src/impq_cmp.sv
src/indexed_min_priority_queue_unit.sv
test/indexed_min_priority_queue_unit_tb.sv
